[rtl/wsd_pkg.sv]
// Shared types and constants for the WebSocket frame deframer.
// Used by the parser, the output register and the top level; no dependencies.
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA,
    PH_HALT
  } phase_t;

  localparam logic [1:0] EV_DATA       = 2'd0;
  localparam logic [1:0] EV_CLOSE_PEER = 2'd1;
  localparam logic [1:0] EV_CLOSE_SIZE = 2'd2;

  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd65536;

  typedef struct packed {
    logic [1:0] event_res;
    logic [3:0] frame_opcode;
    logic [7:0] data;
    logic       last;
  } wsd_result_t;

endpackage

[rtl/wsd_in_reg.sv]
// Input register for received stream bytes.
// Stand-alone; holds one beat until the parser can take it.
module wsd_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  output logic       in_stall,
  input  logic       take,
  output logic       hold_valid,
  output logic [7:0] hold_byte
);

  logic load;

  assign load     = !hold_valid || take;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (load) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      hold_byte <= in_byte;
    end
  end

endmodule

[rtl/wsd_parser.sv]
// Frame header parser, unmasking and close detection for the deframer.
// Depends on wsd_pkg for the phase type, codes and the result struct.
module wsd_parser
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        fire,
  input  logic [7:0]  in_byte,
  output logic        res_valid,
  output wsd_result_t res
);

  phase_t      phase, phase_next;
  logic [3:0]  cur_opcode, cur_opcode_next;
  logic        is_masked, is_masked_next;
  logic [2:0]  ext_len_count, ext_len_count_next;
  logic [63:0] payload_len, payload_len_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_count, mask_count_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] max_payload;

  logic        after_len;
  logic        hdr_done;
  logic        oversize;
  logic [7:0]  key_byte;
  logic        fin;

  always_comb begin
    unique case (byte_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next         = phase;
    cur_opcode_next    = cur_opcode;
    is_masked_next     = is_masked;
    ext_len_count_next = ext_len_count;
    payload_len_next   = payload_len;
    mask_key_next      = mask_key;
    mask_count_next    = mask_count;
    bytes_left_next    = bytes_left;
    byte_index_next    = byte_index;
    res_valid          = 1'b0;
    res                = '{EV_DATA, cur_opcode, 8'h00, 1'b1};
    after_len          = 1'b0;
    hdr_done           = 1'b0;
    oversize           = 1'b0;
    fin                = 1'b0;

    if (fire) begin
      unique case (phase)
        PH_HDR0: begin
          cur_opcode_next = in_byte[3:0];
          phase_next      = PH_HDR1;
        end
        PH_HDR1: begin
          if (cur_opcode == OP_CLOSE) begin
            phase_next = PH_HALT;
            res_valid  = 1'b1;
            res        = '{EV_CLOSE_PEER, cur_opcode, 8'h00, 1'b1};
          end else begin
            is_masked_next   = in_byte[7];
            payload_len_next = '0;
            if (in_byte[6:0] == LEN_EXT16) begin
              ext_len_count_next = 3'd1;
              phase_next         = PH_EXT;
            end else if (in_byte[6:0] == LEN_EXT64) begin
              ext_len_count_next = 3'd7;
              phase_next         = PH_EXT;
            end else begin
              payload_len_next = {57'd0, in_byte[6:0]};
              after_len        = 1'b1;
            end
          end
        end
        PH_EXT: begin
          payload_len_next = {payload_len[55:0], in_byte};
          if (ext_len_count == 3'd0) begin
            after_len = 1'b1;
          end else begin
            ext_len_count_next = ext_len_count - 3'd1;
          end
        end
        PH_KEY: begin
          mask_key_next = {mask_key[23:0], in_byte};
          if (mask_count == 2'd3) begin
            mask_count_next = 2'd0;
            hdr_done        = 1'b1;
          end else begin
            mask_count_next = mask_count + 2'd1;
          end
        end
        PH_DATA: begin
          byte_index_next = byte_index + 2'd1;
          bytes_left_next = bytes_left - 64'd1;
          fin             = (bytes_left == 64'd1);
          if (fin) begin
            phase_next = PH_HDR0;
          end
          if (cur_opcode != OP_PING) begin
            res_valid = 1'b1;
            res       = '{EV_DATA, cur_opcode,
                          in_byte ^ (is_masked ? key_byte : 8'h00), fin};
          end
        end
        PH_HALT: begin
          phase_next = PH_HALT;
        end
        default: begin
          phase_next = PH_HALT;
        end
      endcase

      if (after_len) begin
        if (is_masked_next) begin
          mask_count_next = 2'd0;
          mask_key_next   = '0;
          phase_next      = PH_KEY;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        bytes_left_next = payload_len_next;
        byte_index_next = 2'd0;
        oversize        = (|payload_len_next[63:32]) ||
                          (payload_len_next[31:0] > max_payload);
        if (cur_opcode != OP_PING && oversize) begin
          phase_next = PH_HALT;
          res_valid  = 1'b1;
          res        = '{EV_CLOSE_SIZE, cur_opcode, 8'h00, 1'b1};
        end else if (payload_len_next == 64'd0) begin
          phase_next = PH_HDR0;
        end else begin
          phase_next = PH_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      cur_opcode    <= '0;
      is_masked     <= 1'b0;
      ext_len_count <= '0;
      payload_len   <= '0;
      mask_key      <= '0;
      mask_count    <= '0;
      bytes_left    <= '0;
      byte_index    <= '0;
    end else begin
      phase         <= phase_next;
      cur_opcode    <= cur_opcode_next;
      is_masked     <= is_masked_next;
      ext_len_count <= ext_len_count_next;
      payload_len   <= payload_len_next;
      mask_key      <= mask_key_next;
      mask_count    <= mask_count_next;
      bytes_left    <= bytes_left_next;
      byte_index    <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_data;
    end
  end

endmodule

[rtl/wsd_out_reg.sv]
// Result register that drives the output channel of the deframer.
// Depends on wsd_pkg for the result struct.
module wsd_out_reg
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic        res_valid,
  input  wsd_result_t res,
  output logic        room,
  output logic        out_valid,
  input  logic        out_stall,
  output wsd_result_t out_res
);

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (room) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_valid) begin
      out_res <= res;
    end
  end

endmodule

[rtl/websocket_frame_deframer.sv]
// WebSocket receive-side frame deframer: top level.
// Depends on wsd_pkg, wsd_in_reg, wsd_parser and wsd_out_reg.
//
// The input channel (in_valid, in_stall, in_byte) carries one stream byte
// per beat. The output channel (out_valid, out_stall, event_res,
// frame_opcode, data, last) carries one result per beat: an unmasked
// payload byte, or a single close event for a peer close or an oversize
// frame. Header, extended length and key bytes produce no beat, nor do
// ping payloads. After a close event all further input is taken and dropped.
// cfg_we and cfg_data write the maximum payload length; it should only be
// written while the block is idle.
// A byte accepted into the input register is parsed as it fires, and its
// result is captured in the result register that drives the output. One
// byte per cycle is sustained while the receiver does not stall; the parser
// state update is a single pass per byte through the 64-bit length compare
// and decrement. When the receiver stalls, the result register holds its
// beat, the input register fills, and in_stall rises once it is full.
// Synchronous reset returns to the first header byte, empties both
// registers and sets the maximum payload to 65536 bytes.
module websocket_frame_deframer
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [3:0]  frame_opcode,
  output logic [7:0]  data,
  output logic        last
);

  logic        hold_valid;
  logic [7:0]  hold_byte;
  logic        room;
  logic        fire;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_res;

  assign fire = hold_valid && room;

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_byte    (in_byte),
    .in_stall   (in_stall),
    .take       (room),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .in_byte   (hold_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign event_res    = out_res.event_res;
  assign frame_opcode = out_res.frame_opcode;
  assign data         = out_res.data;
  assign last         = out_res.last;

endmodule

[test/wsd_beat_checker.sv]
`timescale 1ns / 100ps
// Watches both channels of websocket_frame_deframer, predicts each output beat
// from the accepted input bytes and the payload limit, and compares in order.
// Depends on wsd_pkg for the phase type, event codes, opcodes and result type.
module wsd_beat_checker
  import wsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  event_res,
  input  logic [3:0]  frame_opcode,
  input  logic [7:0]  data,
  input  logic        last,
  output int          outstanding,
  output int          failures
);

  phase_t      st;
  logic [3:0]  op;
  logic        masked;
  logic [2:0]  ext_left;
  logic [63:0] frame_len;
  logic [31:0] key;
  logic [1:0]  key_cnt;
  logic [63:0] remaining;
  logic [1:0]  pos;
  logic [31:0] limit;

  wsd_result_t expected_beats[$];
  wsd_result_t predicted;
  wsd_result_t observed;
  wsd_result_t want;
  bit          produced;
  int          mismatches = 0;

  assign failures = mismatches;

  task automatic settle_header(output bit hit, output wsd_result_t r);
    remaining = frame_len;
    pos = 2'd0;
    hit = 1'b0;
    if (op != OP_PING && frame_len > {32'd0, limit}) begin
      st = PH_HALT;
      hit = 1'b1;
      r.event_res = EV_CLOSE_SIZE;
      r.frame_opcode = op;
      r.data = 8'h00;
      r.last = 1'b1;
    end else begin
      st = (frame_len == 64'd0) ? PH_HDR0 : PH_DATA;
    end
  endtask

  task automatic length_known(output bit hit, output wsd_result_t r);
    hit = 1'b0;
    if (masked) begin
      key_cnt = 2'd0;
      key = 32'd0;
      st = PH_KEY;
    end else begin
      settle_header(hit, r);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output bit hit, output wsd_result_t r);
    logic [7:0] plain;
    hit = 1'b0;
    r = '0;
    case (st)
      PH_HDR0: begin
        op = b[3:0];
        st = PH_HDR1;
      end
      PH_HDR1: begin
        if (op == OP_CLOSE) begin
          st = PH_HALT;
          hit = 1'b1;
          r.event_res = EV_CLOSE_PEER;
          r.frame_opcode = op;
          r.data = 8'h00;
          r.last = 1'b1;
        end else begin
          masked = b[7];
          frame_len = 64'd0;
          if (b[6:0] == LEN_EXT16) begin
            ext_left = 3'd1;
            st = PH_EXT;
          end else if (b[6:0] == LEN_EXT64) begin
            ext_left = 3'd7;
            st = PH_EXT;
          end else begin
            frame_len = {57'd0, b[6:0]};
            length_known(hit, r);
          end
        end
      end
      PH_EXT: begin
        frame_len = {frame_len[55:0], b};
        if (ext_left == 3'd0) length_known(hit, r);
        else ext_left = ext_left - 3'd1;
      end
      PH_KEY: begin
        key = {key[23:0], b};
        if (key_cnt == 2'd3) begin
          key_cnt = 2'd0;
          settle_header(hit, r);
        end else begin
          key_cnt = key_cnt + 2'd1;
        end
      end
      PH_DATA: begin
        plain = masked ? (b ^ key[8 * (3 - pos) +: 8]) : b;
        pos = pos + 2'd1;
        remaining = remaining - 64'd1;
        if (remaining == 64'd0) st = PH_HDR0;
        if (op != OP_PING) begin
          hit = 1'b1;
          r.event_res = EV_DATA;
          r.frame_opcode = op;
          r.data = plain;
          r.last = (remaining == 64'd0);
        end
      end
      default: st = PH_HALT;
    endcase
  endtask

  task automatic report_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      st = PH_HDR0;
      op = 4'd0;
      masked = 1'b0;
      ext_left = 3'd0;
      frame_len = 64'd0;
      key = 32'd0;
      key_cnt = 2'd0;
      remaining = 64'd0;
      pos = 2'd0;
      limit = MAX_PAYLOAD_RESET;
      expected_beats.delete();
    end else begin
      if (cfg_we) limit = cfg_data;
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte, produced, predicted);
        if (produced) expected_beats = {expected_beats, predicted};
      end
      if (out_valid && !out_stall) begin
        observed.event_res = event_res;
        observed.frame_opcode = frame_opcode;
        observed.data = data;
        observed.last = last;
        if (expected_beats.size() == 0) begin
          $display("%0t: beat expected none, got event %0h opcode %0h data %0h last %0b",
                   $time, event_res, frame_opcode, data, last);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (observed.event_res !== want.event_res)
            report_field("event_res", 8'(want.event_res), 8'(observed.event_res));
          if (observed.frame_opcode !== want.frame_opcode)
            report_field("frame_opcode", 8'(want.frame_opcode), 8'(observed.frame_opcode));
          if (observed.data !== want.data)
            report_field("data", want.data, observed.data);
          if (observed.last !== want.last)
            report_field("last", 8'(want.last), 8'(observed.last));
        end
      end
    end
    outstanding <= expected_beats.size();
  end

endmodule

[test/tb_websocket_frame_deframer.sv]
`timescale 1ns / 100ps
// Stimulus and verdict for websocket_frame_deframer: frames of every opcode and
// length encoding under several payload limits, ending with one close event.
// Depends on wsd_pkg, the deframer RTL and wsd_beat_checker.
module tb_websocket_frame_deframer
  import wsd_pkg::*;
();

  localparam int ENC_SHORT = 0;
  localparam int ENC_16    = 1;
  localparam int ENC_64    = 2;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_RSV_F  = 4'hF;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = 32'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_res;
  logic [3:0]  frame_opcode;
  logic [7:0]  data;
  logic        last;

  int          outstanding;
  int          failures;
  bit          calm = 1'b0;
  logic [1:0]  stall_run = 2'd0;
  logic [31:0] max_len = MAX_PAYLOAD_RESET;
  int          sent = 0;
  int          mark;

  websocket_frame_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .frame_opcode (frame_opcode),
    .data         (data),
    .last         (last)
  );

  wsd_beat_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_res    (event_res),
    .frame_opcode (frame_opcode),
    .data         (data),
    .last         (last),
    .outstanding  (outstanding),
    .failures     (failures)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
      stall_run <= 2'd0;
    end else if (stall_run != 2'd0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 2'd1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_run <= 2'($urandom_range(0, 2));
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_random_bytes(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= value;
    max_len = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_header(input logic [3:0] op, input logic masked, input logic [63:0] len,
                             input int enc, input logic [31:0] key);
    logic [3:0] flags;
    flags = 4'($urandom);
    send_byte({flags, op});
    case (enc)
      ENC_SHORT: send_byte({masked, len[6:0]});
      ENC_16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
  endtask

  function automatic int pick_encoding(input logic [63:0] len);
    int roll;
    roll = $urandom_range(0, 9);
    if (len > 64'd65535) return ENC_64;
    if (len > 64'd125) return (roll < 7) ? ENC_16 : ENC_64;
    if (roll < 6) return ENC_SHORT;
    return (roll < 8) ? ENC_16 : ENC_64;
  endfunction

  task automatic random_frame();
    logic [3:0]  op;
    logic [63:0] len;
    int          roll;
    op = 4'($urandom);
    while (op == OP_CLOSE) op = 4'($urandom);
    roll = $urandom_range(0, 19);
    if (roll < 13) len = 64'($urandom_range(0, 12));
    else if (roll < 19) len = 64'($urandom_range(13, 60));
    else len = 64'($urandom_range(61, 300));
    if (op != OP_PING && len > {32'd0, max_len})
      len = {32'd0, ($urandom_range(0, 1) != 0) ? max_len : 32'($urandom_range(0, max_len))};
    send_header(op, 1'($urandom_range(0, 1)), len, pick_encoding(len), $urandom);
    send_random_bytes(int'(len));
  endtask

  task automatic closing_frame();
    logic [3:0]  op;
    logic [3:0]  flags;
    logic [63:0] len;
    if ($urandom_range(0, 1) != 0) begin
      flags = 4'($urandom);
      send_byte({flags, OP_CLOSE});
      send_byte(8'($urandom));
    end else begin
      op = 4'($urandom);
      while (op == OP_CLOSE || op == OP_PING) op = 4'($urandom);
      if ($urandom_range(0, 1) != 0) len = {1'b1, 31'($urandom), 32'($urandom)};
      else len = {32'd0, max_len} + 64'd1;
      send_header(op, 1'($urandom_range(0, 1)), len, pick_encoding(len), $urandom);
    end
    send_random_bytes(16);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_header(OP_TEXT, 1'b0, 64'd0, ENC_SHORT, 32'd0);
    send_header(OP_BINARY, 1'b1, 64'd4, ENC_SHORT, 32'hFFFF_FFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_header(OP_PING, 1'b0, 64'd2, ENC_SHORT, 32'd0);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_header(OP_CONT, 1'b0, 64'd1, ENC_16, 32'd0);
    send_byte(8'hFF);
    send_header(OP_RSV_F, 1'b0, 64'd1, ENC_64, 32'd0);
    send_byte(8'h00);

    write_limit(32'd0);
    for (int i = 0; i < 12; i++) random_frame();

    write_limit(32'hFFFF_FFFF);
    mark = sent;
    while (sent < mark + 300) begin
      random_frame();
      if ($urandom_range(0, 15) == 0) drain();
    end

    write_limit($urandom_range(1, 64));
    mark = sent;
    while (sent < mark + 300) random_frame();

    write_limit($urandom);
    mark = sent;
    while (sent < mark + 200) random_frame();
    calm <= 1'b1;
    mark = sent;
    while (sent < mark + 100) random_frame();
    closing_frame();

    drain();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
